@@ rtl/core/pjh_pkg.sv @@
// Package for the pulse jitter histogram: field widths, register codes,
// reset values and the transaction payload structs.
// Depends on nothing; used by pulse_jitter_histogram_top.
package pjh_pkg;

	localparam int BIN_COUNT_DEF = 61;

	localparam int TIME_W  = 20;
	localparam int SETTLE_W = 8;
	localparam int ZBIN_W  = 6;
	localparam int SNAP_W  = 12;
	localparam int CNT_W   = 17;
	localparam int OFF_W   = 7;
	localparam int TICK_W  = 9;
	localparam int CFG_W   = 20;
	localparam int CFGI_W  = 3;

	localparam logic [CNT_W-1:0]    CNT_MAX          = '1;
	localparam logic [TIME_W-1:0]   REQ_TIME_RST     = 20'd0;
	localparam logic [SETTLE_W-1:0] SETTLE_RST       = 8'd10;
	localparam logic [ZBIN_W-1:0]   ZERO_BIN_RST     = 6'd10;
	localparam logic [SNAP_W-1:0]   SNAP_INTERVAL_RST = 12'd60;
	localparam logic [CNT_W-1:0]    EPOCH_LEN_RST    = 17'd86400;

	typedef enum logic [CFGI_W-1:0] {
		CFG_REQUESTED_TIME    = 3'd0,
		CFG_SETTLE_TICKS      = 3'd1,
		CFG_ZERO_BIN          = 3'd2,
		CFG_SNAPSHOT_INTERVAL = 3'd3,
		CFG_EPOCH_LENGTH      = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [TIME_W-1:0] measured_time;
		logic              sample_valid;
	} smp_t;

	typedef struct packed {
		logic signed [OFF_W-1:0] bin_offset;
		logic [CNT_W-1:0]        bin_count;
		logic                    last_bin;
	} bin_t;

endpackage

@@ rtl/core/pulse_jitter_histogram_top.sv @@
// Top level of the pulse jitter histogram: configuration registers,
// sequencer and the bin count memory with per-entry valid bits.
// Depends on pjh_pkg.
//
// One sample transaction per tick. A counted sample costs a read and a
// write-back of its bin in the bin memory (one read port, one write port,
// read data registered). Without a snapshot, a counted item passes through
// S_IDLE, S_UPD, S_POST and S_CLR, and an item that counts nothing skips
// S_UPD. A snapshot streams all BIN_COUNT bins out of the same memory
// port, one per cycle while the output is not stalled, in S_SNAP between
// S_POST and S_CLR. The input stalls until the item is finished. The last
// bin may still wait in the output register while the next sample is taken.
// The store is cleared at reset and at each epoch end through valid bits,
// with no clearing pass.
module pulse_jitter_histogram_top #(
	parameter int BIN_COUNT = pjh_pkg::BIN_COUNT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       smp_valid,
	output logic                       smp_stall,
	input  pjh_pkg::smp_t              smp_data,
	output logic                       bin_valid,
	input  logic                       bin_stall,
	output pjh_pkg::bin_t              bin_data,
	input  logic                       cfg_we,
	input  logic [pjh_pkg::CFGI_W-1:0] cfg_index,
	input  logic [pjh_pkg::CFG_W-1:0]  cfg_data
);

	localparam int AW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(BIN_COUNT - 1);
	localparam int DW = pjh_pkg::TIME_W + 2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UPD,
		S_POST,
		S_SNAP,
		S_CLR
	} state_t;

	state_t state_q;

	logic [pjh_pkg::TIME_W-1:0]   req_time_q;
	logic [pjh_pkg::SETTLE_W-1:0] settle_q;
	logic [pjh_pkg::ZBIN_W-1:0]   zero_bin_q;
	logic [pjh_pkg::SNAP_W-1:0]   snap_int_q;
	logic [pjh_pkg::CNT_W-1:0]    epoch_len_q;

	logic [pjh_pkg::TICK_W-1:0] ticks_q;
	logic [pjh_pkg::CNT_W-1:0]  samples_q;
	logic [pjh_pkg::SNAP_W-1:0] phase_q;

	logic [pjh_pkg::CNT_W-1:0] mem [BIN_COUNT];
	logic [BIN_COUNT-1:0]      vld_q;
	logic [pjh_pkg::CNT_W-1:0] rdata_s1;
	logic                      rvld_s1;

	logic [AW-1:0] upd_idx_q;
	logic [AW-1:0] rd_idx_q;
	logic [AW-1:0] ld_idx_q;
	logic          pend_q;
	logic          issued_q;

	logic          bin_valid_q;
	pjh_pkg::bin_t bin_data_q;

	logic                      accept;
	logic                      counts;
	logic signed [DW-1:0]      diff;
	logic [AW-1:0]             idx_c;
	logic                      re;
	logic [AW-1:0]             raddr;
	logic                      we;
	logic [pjh_pkg::CNT_W-1:0] cur_cnt;
	logic [pjh_pkg::CNT_W-1:0] new_cnt;
	logic [pjh_pkg::SNAP_W:0]  phase_inc;
	logic                      out_free;
	logic                      load;
	logic                      issue;

	assign smp_stall = (state_q != S_IDLE);
	assign accept    = smp_valid && !smp_stall;
	assign counts    = smp_data.sample_valid && (ticks_q > {1'b0, settle_q});

	assign diff = $signed({2'b00, smp_data.measured_time}) - $signed({2'b00, req_time_q})
		+ $signed({{(DW - pjh_pkg::ZBIN_W){1'b0}}, zero_bin_q});

	always_comb begin
		if (diff < 0) begin
			idx_c = '0;
		end else if (diff > $signed(DW'(BIN_COUNT - 1))) begin
			idx_c = LAST_IDX;
		end else begin
			idx_c = diff[AW-1:0];
		end
	end

	assign out_free = !bin_valid_q || !bin_stall;
	assign load     = (state_q == S_SNAP) && pend_q && out_free;
	assign issue    = (state_q == S_SNAP) && !issued_q && (!pend_q || load);

	assign re    = (accept && counts) || issue;
	assign raddr = (state_q == S_SNAP) ? rd_idx_q : idx_c;
	assign we    = (state_q == S_UPD);

	assign cur_cnt   = rvld_s1 ? rdata_s1 : '0;
	assign new_cnt   = (cur_cnt == pjh_pkg::CNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
	assign phase_inc = {1'b0, phase_q} + 1'b1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[upd_idx_q] <= new_cnt;
		end
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_time_q  <= pjh_pkg::REQ_TIME_RST;
			settle_q    <= pjh_pkg::SETTLE_RST;
			zero_bin_q  <= pjh_pkg::ZERO_BIN_RST;
			snap_int_q  <= pjh_pkg::SNAP_INTERVAL_RST;
			epoch_len_q <= pjh_pkg::EPOCH_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pjh_pkg::CFG_REQUESTED_TIME: begin
					req_time_q <= cfg_data[pjh_pkg::TIME_W-1:0];
				end
				pjh_pkg::CFG_SETTLE_TICKS: begin
					settle_q <= cfg_data[pjh_pkg::SETTLE_W-1:0];
				end
				pjh_pkg::CFG_ZERO_BIN: begin
					zero_bin_q <= cfg_data[pjh_pkg::ZBIN_W-1:0];
				end
				pjh_pkg::CFG_SNAPSHOT_INTERVAL: begin
					snap_int_q <= cfg_data[pjh_pkg::SNAP_W-1:0];
				end
				pjh_pkg::CFG_EPOCH_LENGTH: begin
					epoch_len_q <= cfg_data[pjh_pkg::CNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ticks_q     <= '0;
			samples_q   <= '0;
			phase_q     <= '0;
			vld_q       <= '0;
			rvld_s1     <= 1'b0;
			upd_idx_q   <= '0;
			rd_idx_q    <= '0;
			ld_idx_q    <= '0;
			pend_q      <= 1'b0;
			issued_q    <= 1'b0;
			bin_valid_q <= 1'b0;
		end else begin
			if (re) begin
				rvld_s1 <= vld_q[raddr];
			end
			if (load) begin
				bin_valid_q           <= 1'b1;
				bin_data_q.bin_offset <= pjh_pkg::OFF_W'(ld_idx_q)
					- pjh_pkg::OFF_W'(zero_bin_q);
				bin_data_q.bin_count  <= rvld_s1 ? rdata_s1 : '0;
				bin_data_q.last_bin   <= (ld_idx_q == LAST_IDX);
			end else if (!bin_stall) begin
				bin_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						upd_idx_q <= idx_c;
						if (ticks_q <= {1'b0, settle_q}) begin
							ticks_q <= ticks_q + 1'b1;
						end
						state_q <= counts ? S_UPD : S_POST;
					end
				end
				S_UPD: begin
					vld_q[upd_idx_q] <= 1'b1;
					if (samples_q != pjh_pkg::CNT_MAX) begin
						samples_q <= samples_q + 1'b1;
					end
					if (phase_inc >= {1'b0, snap_int_q}) begin
						phase_q <= '0;
					end else begin
						phase_q <= phase_inc[pjh_pkg::SNAP_W-1:0];
					end
					state_q <= S_POST;
				end
				S_POST: begin
					rd_idx_q <= '0;
					pend_q   <= 1'b0;
					issued_q <= 1'b0;
					state_q  <= (phase_q == '0) ? S_SNAP : S_CLR;
				end
				S_SNAP: begin
					if (issue) begin
						ld_idx_q <= rd_idx_q;
						rd_idx_q <= rd_idx_q + 1'b1;
						pend_q   <= 1'b1;
						if (rd_idx_q == LAST_IDX) begin
							issued_q <= 1'b1;
						end
					end else if (load) begin
						pend_q <= 1'b0;
					end
					if (load && ld_idx_q == LAST_IDX) begin
						state_q <= S_CLR;
					end
				end
				S_CLR: begin
					if (samples_q >= epoch_len_q) begin
						vld_q     <= '0;
						samples_q <= '0;
						phase_q   <= '0;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign bin_valid = bin_valid_q;
	assign bin_data  = bin_data_q;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for pulse_jitter_histogram_top: queue-fed sample driver,
// clocked snapshot monitor and a tick-accurate histogram predictor.
// Depends on pjh_pkg and pulse_jitter_histogram_top.
module tb_top;

	localparam int LIMIT = 4000;
	localparam int SEG_ITEMS = 38;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         smp_valid = 1'b0;
	logic                         smp_stall;
	pjh_pkg::smp_t                smp_data = '0;
	logic                         bin_valid;
	logic                         bin_stall = 1'b0;
	pjh_pkg::bin_t                bin_data;
	logic                         cfg_we = 1'b0;
	logic [pjh_pkg::CFGI_W-1:0]   cfg_index = '0;
	logic [pjh_pkg::CFG_W-1:0]    cfg_data = '0;

	pulse_jitter_histogram_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.smp_data  (smp_data),
		.bin_valid (bin_valid),
		.bin_stall (bin_stall),
		.bin_data  (bin_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	logic [pjh_pkg::TIME_W-1:0]   req_time_r;
	logic [pjh_pkg::SETTLE_W-1:0] settle_r;
	logic [pjh_pkg::ZBIN_W-1:0]   zero_bin_r;
	logic [pjh_pkg::SNAP_W-1:0]   snap_int_r;
	logic [pjh_pkg::CNT_W-1:0]    epoch_len_r;

	logic [pjh_pkg::CNT_W-1:0]    hist [pjh_pkg::BIN_COUNT_DEF];
	logic [pjh_pkg::TICK_W-1:0]   ticks_seen;
	logic [pjh_pkg::CNT_W-1:0]    epoch_samples;
	logic [pjh_pkg::SNAP_W-1:0]   snap_phase;

	pjh_pkg::smp_t ticks_pending [$];
	bit            pause_q [$];
	pjh_pkg::bin_t bins_due [$];
	int unsigned   snd_idle = 8;
	int unsigned   rcv_idle = 59;
	int unsigned   pushed_cnt = 0;
	int unsigned   taken_cnt = 0;
	int unsigned   errors = 0;
	int unsigned   quiet = 0;
	logic          smp_took = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic void tally_tick(pjh_pkg::smp_t s);
		int idx;
		int zb;
		logic [pjh_pkg::SNAP_W:0] nxt;
		pjh_pkg::bin_t b;
		zb = int'(zero_bin_r);
		if (s.sample_valid && ticks_seen > pjh_pkg::TICK_W'(settle_r)) begin
			idx = int'(s.measured_time) - int'(req_time_r) + zb;
			if (idx < 0) idx = 0;
			if (idx > pjh_pkg::BIN_COUNT_DEF - 1) idx = pjh_pkg::BIN_COUNT_DEF - 1;
			if (hist[idx] < pjh_pkg::CNT_MAX) hist[idx] = hist[idx] + 1'b1;
			if (epoch_samples < pjh_pkg::CNT_MAX) epoch_samples = epoch_samples + 1'b1;
			nxt = {1'b0, snap_phase} + 1'b1;
			snap_phase = (nxt >= {1'b0, snap_int_r}) ? '0 : nxt[pjh_pkg::SNAP_W-1:0];
		end
		if (ticks_seen <= pjh_pkg::TICK_W'(settle_r)) ticks_seen = ticks_seen + 1'b1;
		if (snap_phase == '0) begin
			for (int i = 0; i < pjh_pkg::BIN_COUNT_DEF; i++) begin
				b.bin_offset = pjh_pkg::OFF_W'(i - zb);
				b.bin_count  = hist[i];
				b.last_bin   = (i == pjh_pkg::BIN_COUNT_DEF - 1);
				bins_due.push_back(b);
			end
		end
		if (epoch_samples >= epoch_len_r) begin
			foreach (hist[i]) hist[i] = '0;
			epoch_samples = '0;
			snap_phase = '0;
		end
	endfunction

	function automatic logic [pjh_pkg::TIME_W-1:0] near_req(int spread);
		int m;
		m = int'(req_time_r) + int'($urandom_range(2 * spread)) - spread;
		if (m < 0) m = 0;
		if (m > 999999) m = 999999;
		return pjh_pkg::TIME_W'(m);
	endfunction

	task automatic queue_sample(logic [pjh_pkg::TIME_W-1:0] m, logic v, bit pause);
		pjh_pkg::smp_t s;
		s.measured_time = m;
		s.sample_valid = v;
		ticks_pending.push_back(s);
		pause_q.push_back(pause);
		pushed_cnt++;
	endtask

	task automatic queue_dev(int dev, logic v);
		queue_sample(pjh_pkg::TIME_W'(int'(req_time_r) + dev), v, 1'b0);
	endtask

	task automatic drain();
		while (taken_cnt != pushed_cnt || bins_due.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_reg(pjh_pkg::cfg_idx_t idx, logic [pjh_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		unique case (idx)
			pjh_pkg::CFG_REQUESTED_TIME:    req_time_r = val[pjh_pkg::TIME_W-1:0];
			pjh_pkg::CFG_SETTLE_TICKS:      settle_r = val[pjh_pkg::SETTLE_W-1:0];
			pjh_pkg::CFG_ZERO_BIN:          zero_bin_r = val[pjh_pkg::ZBIN_W-1:0];
			pjh_pkg::CFG_SNAPSHOT_INTERVAL: snap_int_r = val[pjh_pkg::SNAP_W-1:0];
			pjh_pkg::CFG_EPOCH_LENGTH:      epoch_len_r = val[pjh_pkg::CNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(int req, int settle, int zb, int si, int ep);
		write_reg(pjh_pkg::CFG_REQUESTED_TIME, pjh_pkg::CFG_W'(req));
		write_reg(pjh_pkg::CFG_SETTLE_TICKS, pjh_pkg::CFG_W'(settle));
		write_reg(pjh_pkg::CFG_ZERO_BIN, pjh_pkg::CFG_W'(zb));
		write_reg(pjh_pkg::CFG_SNAPSHOT_INTERVAL, pjh_pkg::CFG_W'(si));
		write_reg(pjh_pkg::CFG_EPOCH_LENGTH, pjh_pkg::CFG_W'(ep));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!smp_valid || smp_took) begin
				if (ticks_pending.size() != 0 && !(pause_q[0] && bins_due.size() != 0) &&
				    $urandom_range(99) >= snd_idle) begin
					smp_data <= ticks_pending.pop_front();
					void'(pause_q.pop_front());
					smp_valid <= 1'b1;
				end else begin
					smp_valid <= 1'b0;
				end
			end
			bin_stall <= ($urandom_range(99) < rcv_idle);
		end
	end

	always @(posedge clk) begin
		pjh_pkg::bin_t want;
		if (arst_n) begin
			smp_took <= smp_valid && !smp_stall;
			if (smp_valid && !smp_stall) begin
				tally_tick(smp_data);
				taken_cnt++;
			end
			if (bin_valid && !bin_stall) begin
				if (bins_due.size() == 0) begin
					errors++;
					$display("%0t unexpected bin: offset %0d count %0d last %0b", $time,
						$signed(bin_data.bin_offset), bin_data.bin_count, bin_data.last_bin);
				end else begin
					want = bins_due.pop_front();
					if (bin_data.bin_offset !== want.bin_offset ||
					    bin_data.bin_count !== want.bin_count ||
					    bin_data.last_bin !== want.last_bin) begin
						errors++;
						$display({"%0t bin mismatch: expected offset %0d count %0d last %0b,",
							" got offset %0d count %0d last %0b"},
							$time, $signed(want.bin_offset), want.bin_count, want.last_bin,
							$signed(bin_data.bin_offset), bin_data.bin_count,
							bin_data.last_bin);
					end
				end
			end
			if ((smp_valid && !smp_stall) || (bin_valid && !bin_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= LIMIT) begin
					$display("Regression FAIL");
					$finish;
				end
			end
		end
	end

	initial begin
		int req, settle, zb, si, ep, r, pause_at;
		req_time_r = pjh_pkg::REQ_TIME_RST;
		settle_r = pjh_pkg::SETTLE_RST;
		zero_bin_r = pjh_pkg::ZERO_BIN_RST;
		snap_int_r = pjh_pkg::SNAP_INTERVAL_RST;
		epoch_len_r = pjh_pkg::EPOCH_LEN_RST;
		foreach (hist[i]) hist[i] = '0;
		ticks_seen = '0;
		epoch_samples = '0;
		snap_phase = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// settling ticks under reset values: nothing counted, every tick snapshots
		queue_sample(20'd0, 1'b1, 1'b0);
		queue_sample(20'd999999, 1'b1, 1'b0);
		queue_sample(20'd5, 1'b0, 1'b0);
		drain();

		// bin edges, clamping both ways, bad read, epoch end on a snapshot
		set_regs(500000, 0, 10, 4, 8);
		queue_dev(0, 1'b1);
		queue_dev(-10, 1'b1);
		queue_dev(-11, 1'b1);
		queue_dev(50, 1'b1);
		queue_dev(3, 1'b0);
		queue_dev(51, 1'b1);
		queue_sample(20'd0, 1'b1, 1'b0);
		queue_sample(20'd999999, 1'b1, 1'b0);
		queue_dev(0, 1'b1);
		drain();

		// zero bin past the top, interval zero: every tick snapshots
		set_regs(0, 0, 63, 0, 5);
		queue_sample(20'd0, 1'b1, 1'b0);
		queue_sample(20'd1, 1'b1, 1'b0);
		queue_sample(20'd2, 1'b0, 1'b0);
		queue_sample(20'd2, 1'b1, 1'b0);
		drain();

		// epoch length zero: cleared every tick
		set_regs(1000, 0, 0, 3, 0);
		queue_dev(2, 1'b1);
		queue_dev(-5, 1'b1);
		drain();

		// epoch length not a multiple of the interval
		set_regs(1000, 0, 0, 4, 6);
		for (int k = 0; k < 8; k++) queue_dev(k, 1'b1);
		drain();

		for (int seg = 0; seg < 12; seg++) begin
			if (seg == 4) begin
				snd_idle = 59;
				rcv_idle = 8;
			end else if (seg == 8) begin
				snd_idle = 0;
				rcv_idle = 0;
			end
			req = (seg == 0) ? 0 : (seg == 1) ? 999999 : int'($urandom_range(999999));
			settle = (seg == 5) ? 255 : int'($urandom_range(4));
			zb = (seg == 2) ? 0 : (seg == 3) ? 60 : int'($urandom_range(60));
			si = (seg == 4) ? 4095 : (seg == 6) ? 1 : int'($urandom_range(12, 2));
			ep = (seg == 4) ? 131071 : (seg == 7) ? int'($urandom_range(40, 1)) :
				si * int'($urandom_range(6, 1));
			set_regs(req, settle, zb, si, ep);
			pause_at = int'($urandom_range(SEG_ITEMS - 1, 1));
			for (int k = 0; k < SEG_ITEMS; k++) begin
				r = int'($urandom_range(99));
				if (r < 8)
					queue_sample(20'($urandom_range(999999)), 1'b0, k == pause_at);
				else if (r < 14)
					queue_sample(20'($urandom_range(999999)), 1'b1, k == pause_at);
				else
					queue_sample(near_req(70), 1'b1, k == pause_at);
			end
			drain();
		end

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
